// ===== rtl/bap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants of the block-average pixelation block.
// ----------------------------------------------------------------------------
package bap_pkg;

	localparam int SUM_W   = 22;  // per-channel tile sum
	localparam int TC_W    = 10;  // tile column / row field width
	localparam int IMG_W   = 11;  // image size register width
	localparam int TILE_W  = 7;   // tile size register width
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [MODE_W-1:0] MODE_ORIG   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CORNER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AVG    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_start;
	} pix_t;

	typedef struct packed {
		logic [TC_W-1:0] tile_column;
		logic [TC_W-1:0] tile_row;
		logic [7:0]      red_out;
		logic [7:0]      green_out;
		logic [7:0]      blue_out;
		logic            frame_end;
	} tile_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/block_average_pixelate_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_pixelate_top
// Mosaic pixelation of a raster RGB stream: original, corner or tile average.
// ----------------------------------------------------------------------------
// A pixel word is taken only while the block is idle: the tile-column sum is
// read from RAM in the cycle the pixel is accepted and written back the next.
// A word that completes an average tile holds the input while a restoring
// divider produces one quotient bit per cycle for all three channels. Any
// word that makes a result then waits in the emit state until the output
// register is free and loads it. The sum RAM holds one entry per tile column
// and needs no clearing.
module block_average_pixelate_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_TILE   = 100
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pix_valid,
	output logic                                  pix_stall,
	input  wire bap_pkg::pix_t                    pix,
	output logic                                  tile_valid,
	input  wire logic                             tile_stall,
	output bap_pkg::tile_t                        tile,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bap_pkg::IMG_W-1:0]        cfg_data
);

	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int OW    = $clog2(MAX_TILE + 1);
	localparam int NW    = 2 * OW;
	localparam int DEPTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = bap_pkg::SUM_W;
	localparam int CW    = $clog2(SW);
	localparam int TCW   = bap_pkg::TC_W;

	// configuration
	logic [bap_pkg::IMG_W-1:0]  img_w_q, img_h_q;
	logic [bap_pkg::TILE_W-1:0] tile_w_q, tile_h_q;
	logic [bap_pkg::MODE_W-1:0] mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= bap_pkg::IMG_W'(640);
			img_h_q  <= bap_pkg::IMG_W'(480);
			tile_w_q <= bap_pkg::TILE_W'(10);
			tile_h_q <= bap_pkg::TILE_W'(10);
			mode_q   <= bap_pkg::MODE_AVG;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bap_pkg::CFG_IMG_W:  img_w_q  <= cfg_data;
				bap_pkg::CFG_IMG_H:  img_h_q  <= cfg_data;
				bap_pkg::CFG_TILE_W: tile_w_q <= cfg_data[bap_pkg::TILE_W-1:0];
				bap_pkg::CFG_TILE_H: tile_h_q <= cfg_data[bap_pkg::TILE_W-1:0];
				bap_pkg::CFG_MODE:   mode_q   <= cfg_data[bap_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped sizes
	logic [XW-1:0] w_c;
	logic [YW-1:0] h_c;
	logic [OW-1:0] tw_c, th_c;

	always_comb begin
		if (img_w_q == '0)            w_c = XW'(1);
		else if (img_w_q > MAX_WIDTH) w_c = XW'(MAX_WIDTH);
		else                          w_c = XW'(img_w_q);
		if (img_h_q == '0)             h_c = YW'(1);
		else if (img_h_q > MAX_HEIGHT) h_c = YW'(MAX_HEIGHT);
		else                           h_c = YW'(img_h_q);
		if (tile_w_q == '0)            tw_c = OW'(1);
		else if (tile_w_q > MAX_TILE)  tw_c = OW'(MAX_TILE);
		else                           tw_c = OW'(tile_w_q);
		if (tile_h_q == '0)            th_c = OW'(1);
		else if (tile_h_q > MAX_TILE)  th_c = OW'(MAX_TILE);
		else                           th_c = OW'(tile_h_q);
	end

	// position state
	logic [XW-1:0]  col_q;
	logic [YW-1:0]  row_q;
	logic [OW-1:0]  ox_q, oy_q;
	logic [TCW-1:0] tc_q, tr_q;

	bap_pkg::state_t st_q, st_d;
	logic accept;

	// normalized position of the incoming pixel and the position after it
	logic [XW-1:0]  a_col, n_col;
	logic [YW-1:0]  a_row, n_row;
	logic [OW-1:0]  a_ox, a_oy, n_ox, n_oy;
	logic [TCW-1:0] a_tc, a_tr, n_tc, n_tr;

	always_comb begin
		a_col = col_q;
		a_row = row_q;
		a_ox  = ox_q;
		a_oy  = oy_q;
		a_tc  = tc_q;
		a_tr  = tr_q;
		if (pix.frame_start) begin
			a_col = '0;
			a_row = '0;
			a_ox  = '0;
			a_oy  = '0;
			a_tc  = '0;
			a_tr  = '0;
		end
		if (a_col >= w_c) begin
			a_col = '0;
			a_ox  = '0;
			a_tc  = '0;
			a_row = a_row + YW'(1);
			a_oy  = a_oy + OW'(1);
		end
		if (a_row >= h_c) begin
			a_row = '0;
			a_oy  = '0;
			a_tr  = '0;
		end
		if (a_ox >= tw_c) begin
			a_ox = '0;
			a_tc = a_tc + TCW'(1);
		end
		if (a_oy >= th_c) begin
			a_oy = '0;
			a_tr = a_tr + TCW'(1);
		end

		n_col = a_col;
		n_row = a_row;
		n_ox  = a_ox;
		n_oy  = a_oy;
		n_tc  = a_tc;
		n_tr  = a_tr;
		if (a_col >= w_c - XW'(1)) begin
			n_col = '0;
			n_ox  = '0;
			n_tc  = '0;
			if (a_row >= h_c - YW'(1)) begin
				n_row = '0;
				n_oy  = '0;
				n_tr  = '0;
			end else begin
				n_row = a_row + YW'(1);
				if (a_oy >= th_c - OW'(1)) begin
					n_oy = '0;
					n_tr = a_tr + TCW'(1);
				end else begin
					n_oy = a_oy + OW'(1);
				end
			end
		end else begin
			n_col = a_col + XW'(1);
			if (a_ox >= tw_c - OW'(1)) begin
				n_ox = '0;
				n_tc = a_tc + TCW'(1);
			end else begin
				n_ox = a_ox + OW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			tc_q  <= '0;
			tr_q  <= '0;
		end else if (accept) begin
			col_q <= n_col;
			row_q <= n_row;
			ox_q  <= n_ox;
			oy_q  <= n_oy;
			tc_q  <= n_tc;
			tr_q  <= n_tr;
		end
	end

	// stage 1: pixel and its position, sum read in flight
	logic [XW-1:0]  x_s1;
	logic [YW-1:0]  y_s1;
	logic [OW-1:0]  ox_s1, oy_s1;
	logic [TCW-1:0] tc_s1, tr_s1;
	logic [7:0]     r_s1, g_s1, b_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1  <= a_col;
			y_s1  <= a_row;
			ox_s1 <= a_ox;
			oy_s1 <= a_oy;
			tc_s1 <= a_tc;
			tr_s1 <= a_tr;
			r_s1  <= pix.red_in;
			g_s1  <= pix.green_in;
			b_s1  <= pix.blue_in;
		end
	end

	// tile sum RAM, {red, green, blue}
	logic            ram_we;
	logic [3*SW-1:0] ram_wdata, ram_rdata;

	bap_ram #(
		.WIDTH (3 * SW),
		.DEPTH (DEPTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tc_s1[AW-1:0]),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (a_tc[AW-1:0]),
		.rdata (ram_rdata)
	);

	// accumulate and tile geometry
	logic [XW-1:0] sx, rem_w;
	logic [YW-1:0] sy, rem_h;
	logic [OW-1:0] cw, ch;
	logic          first, avg_hit, corner_end, last_pix;
	logic [SW-1:0] sum_r, sum_g, sum_b;
	logic [NW-1:0] n_cnt;

	always_comb begin
		sx      = x_s1 - XW'(ox_s1);
		sy      = y_s1 - YW'(oy_s1);
		rem_w   = w_c - sx;
		rem_h   = h_c - sy;
		cw      = (rem_w < XW'(tw_c)) ? OW'(rem_w) : tw_c;
		ch      = (rem_h < YW'(th_c)) ? OW'(rem_h) : th_c;
		first   = (ox_s1 == '0) && (oy_s1 == '0);
		avg_hit = (ox_s1 == cw - OW'(1)) && (oy_s1 == ch - OW'(1));
		// bottom-right tile: the tile reaches the image edge both ways
		corner_end = (rem_w <= XW'(tw_c)) && (rem_h <= YW'(th_c));
		last_pix   = (x_s1 == w_c - XW'(1)) && (y_s1 == h_c - YW'(1));
		n_cnt   = NW'(cw) * NW'(ch);
		if (first) begin
			sum_r = SW'(r_s1);
			sum_g = SW'(g_s1);
			sum_b = SW'(b_s1);
		end else begin
			sum_r = ram_rdata[3*SW-1:2*SW] + SW'(r_s1);
			sum_g = ram_rdata[2*SW-1:SW] + SW'(g_s1);
			sum_b = ram_rdata[SW-1:0] + SW'(b_s1);
		end
		ram_wdata = {sum_r, sum_g, sum_b};
	end

	logic emit_now, emit_avg;

	always_comb begin
		case (mode_q)
			bap_pkg::MODE_ORIG: begin
				emit_now = 1'b1;
				emit_avg = 1'b0;
			end
			bap_pkg::MODE_CORNER: begin
				emit_now = first;
				emit_avg = 1'b0;
			end
			default: begin
				emit_now = 1'b0;
				emit_avg = avg_hit;
			end
		endcase
	end

	// divider: three lanes, one quotient bit per cycle
	logic [NW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] rem_q [3];
	logic [SW-1:0] dvd_q [3];
	logic [NW-1:0] rem_d [3];
	logic [SW-1:0] dvd_d [3];
	logic [NW:0]   shl   [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shl[i] = {rem_q[i], dvd_q[i][SW-1]};
			if (shl[i] >= {1'b0, n_q}) begin
				rem_d[i] = NW'(shl[i] - {1'b0, n_q});
				dvd_d[i] = {dvd_q[i][SW-2:0], 1'b1};
			end else begin
				rem_d[i] = shl[i][NW-1:0];
				dvd_d[i] = {dvd_q[i][SW-2:0], 1'b0};
			end
		end
	end

	logic div_last, tile_free, load_out;

	assign div_last  = (cnt_q == CW'(SW - 1));
	assign tile_free = !tile_valid || !tile_stall;

	// FSM next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			bap_pkg::ST_IDLE: if (pix_valid) st_d = bap_pkg::ST_ACC;
			bap_pkg::ST_ACC: begin
				if (emit_now)      st_d = bap_pkg::ST_EMIT;
				else if (emit_avg) st_d = bap_pkg::ST_DIV;
				else               st_d = bap_pkg::ST_IDLE;
			end
			bap_pkg::ST_DIV:  if (div_last) st_d = bap_pkg::ST_EMIT;
			bap_pkg::ST_EMIT: if (tile_free) st_d = bap_pkg::ST_IDLE;
			default: st_d = bap_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		pix_stall = (st_q != bap_pkg::ST_IDLE);
		ram_we    = (st_q == bap_pkg::ST_ACC);
		load_out  = (st_q == bap_pkg::ST_EMIT) && tile_free;
	end

	assign accept = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= bap_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == bap_pkg::ST_DIV) cnt_q <= cnt_q + CW'(1);
			else                         cnt_q <= '0;
		end
	end

	// pending result and divider datapath
	bap_pkg::tile_t res_q;

	always_ff @(posedge clk) begin
		if (st_q == bap_pkg::ST_ACC) begin
			n_q      <= n_cnt;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			rem_q[2] <= '0;
			dvd_q[0] <= sum_r;
			dvd_q[1] <= sum_g;
			dvd_q[2] <= sum_b;
			res_q.red_out   <= r_s1;
			res_q.green_out <= g_s1;
			res_q.blue_out  <= b_s1;
			if (mode_q == bap_pkg::MODE_ORIG) begin
				res_q.tile_column <= TCW'(x_s1);
				res_q.tile_row    <= TCW'(y_s1);
				res_q.frame_end   <= last_pix;
			end else begin
				res_q.tile_column <= tc_s1;
				res_q.tile_row    <= tr_s1;
				res_q.frame_end   <= (mode_q == bap_pkg::MODE_CORNER) ? corner_end
				                                                      : last_pix;
			end
		end else if (st_q == bap_pkg::ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_d[i];
				dvd_q[i] <= dvd_d[i];
			end
			if (div_last) begin
				res_q.red_out   <= dvd_d[0][7:0];
				res_q.green_out <= dvd_d[1][7:0];
				res_q.blue_out  <= dvd_d[2][7:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_valid <= 1'b0;
		end else if (load_out) begin
			tile_valid <= 1'b1;
		end else if (!tile_stall) begin
			tile_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) tile <= res_q;
	end

	// checks
	a_accept_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q == bap_pkg::ST_ACC)
		else $error("accepted word did not move to accumulate");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == bap_pkg::ST_DIV |-> cnt_q < CW'(SW))
		else $error("divider count out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == bap_pkg::ST_DIV |-> n_q != '0)
		else $error("zero pixel count in divide");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		ox_q < OW'(MAX_TILE) && oy_q < OW'(MAX_TILE))
		else $error("tile offset beyond max tile size");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(tile_valid && tile_stall))
		else $error("output word overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/bap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_block_average_pixelate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_pixelate_top
// Self-checking bench for the mosaic pixelation block. A directed table walks
// every mode, clamped registers and clipped edge tiles; random pixel frames
// under several register settings and idle/stall patterns follow. Every
// accepted pixel runs through a local tile predictor and the output words are
// compared field by field, in order, with the predicted queue.
// ----------------------------------------------------------------------------
module tb_block_average_pixelate_top;

	localparam logic [bap_pkg::MODE_W-1:0] MODE_AVG_ALT = 2'd3;  // decodes as average
	localparam int LIMIT_CYCLES = 800000;
	localparam int DRAIN_CYCLES = 60;
	localparam int N_DIR = 30;
	localparam int N_PHASE = 9;

	typedef struct {
		bit                            is_cfg;
		logic [bap_pkg::CFG_IDX_W-1:0] idx;
		logic [bap_pkg::IMG_W-1:0]     data;
		bap_pkg::pix_t                 px;
		bit                            typed;
		bap_pkg::tile_t                want;
	} dir_row_t;

	typedef struct {
		int unsigned                w, h, tw, th;
		logic [bap_pkg::MODE_W-1:0] mode;
		int                         n_pix;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	bap_pkg::pix_t pix = '0;
	logic tile_valid;
	logic tile_stall = 1'b0;
	bap_pkg::tile_t tile;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bap_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bap_pkg::IMG_W-1:0] cfg_data = '0;

	block_average_pixelate_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.tile_valid(tile_valid), .tile_stall(tile_stall), .tile(tile),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [bap_pkg::IMG_W-1:0]  reg_w = 11'd640, reg_h = 11'd480;
	logic [bap_pkg::TILE_W-1:0] reg_tw = 7'd10, reg_th = 7'd10;
	logic [bap_pkg::MODE_W-1:0] reg_mode = bap_pkg::MODE_AVG;
	int unsigned col_pos, row_pos, off_x, off_y, tile_col, tile_row;
	int unsigned sum_r [1024], sum_g [1024], sum_b [1024];

	bap_pkg::tile_t tiles_due [$];
	int errors = 0, n_pix_sent = 0, n_tiles_seen = 0;
	int cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;

	function automatic int unsigned clamp_sz(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Advances the tile counters by one pixel; returns 1 when a word is due.
	function automatic bit predict_tile(bap_pkg::pix_t p, output bap_pkg::tile_t t);
		int unsigned w, h, tw, th, x, y, ox, oy, sx, sy, cw, ch, idx, n;
		bit hit;
		w = clamp_sz(32'(reg_w), 1024);
		h = clamp_sz(32'(reg_h), 1024);
		tw = clamp_sz(32'(reg_tw), 100);
		th = clamp_sz(32'(reg_th), 100);
		hit = 0;
		t = '0;
		if (p.frame_start) begin
			col_pos = 0; row_pos = 0; off_x = 0; off_y = 0; tile_col = 0; tile_row = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0; off_x = 0; tile_col = 0; row_pos++; off_y++;
		end
		if (row_pos >= h) begin
			row_pos = 0; off_y = 0; tile_row = 0;
		end
		if (off_x >= tw) begin
			off_x = 0; tile_col = (tile_col + 1) & 10'h3ff;
		end
		if (off_y >= th) begin
			off_y = 0; tile_row = (tile_row + 1) & 10'h3ff;
		end
		x = col_pos; y = row_pos; ox = off_x; oy = off_y;
		sx = x - ox; sy = y - oy;
		cw = (w - sx < tw) ? w - sx : tw;
		ch = (h - sy < th) ? h - sy : th;
		idx = tile_col % 1024;
		if (ox == 0 && oy == 0) begin
			sum_r[idx] = 32'(p.red_in); sum_g[idx] = 32'(p.green_in);
			sum_b[idx] = 32'(p.blue_in);
		end else begin
			sum_r[idx] += 32'(p.red_in); sum_g[idx] += 32'(p.green_in);
			sum_b[idx] += 32'(p.blue_in);
		end
		if (reg_mode == bap_pkg::MODE_ORIG) begin
			t = '{x[9:0], y[9:0], p.red_in, p.green_in, p.blue_in,
				(x == w - 1 && y == h - 1)};
			hit = 1;
		end else if (reg_mode == bap_pkg::MODE_CORNER) begin
			if (ox == 0 && oy == 0) begin
				t = '{tile_col[9:0], tile_row[9:0], p.red_in, p.green_in, p.blue_in,
					(sx + tw >= w && sy + th >= h)};
				hit = 1;
			end
		end else if (ox + 1 == cw && oy + 1 == ch) begin
			n = cw * ch;
			t.tile_column = tile_col[9:0];
			t.tile_row = tile_row[9:0];
			t.red_out = 8'(sum_r[idx] / n);
			t.green_out = 8'(sum_g[idx] / n);
			t.blue_out = 8'(sum_b[idx] / n);
			t.frame_end = (x == w - 1 && y == h - 1);
			hit = 1;
		end
		if (x + 1 >= w) begin
			col_pos = 0; off_x = 0; tile_col = 0;
			if (y + 1 >= h) begin
				row_pos = 0; off_y = 0; tile_row = 0;
			end else begin
				row_pos = y + 1;
				if (oy + 1 >= th) begin
					off_y = 0; tile_row = (tile_row + 1) & 10'h3ff;
				end else begin
					off_y = oy + 1;
				end
			end
		end else begin
			col_pos = x + 1;
			if (ox + 1 >= tw) begin
				off_x = 0; tile_col = (tile_col + 1) & 10'h3ff;
			end else begin
				off_x = ox + 1;
			end
		end
		return hit;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d words outstanding", $time, tiles_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output checker
	always @(posedge clk) begin
		bap_pkg::tile_t want;
		if (arst_n && tile_valid && !tile_stall) begin
			n_tiles_seen++;
			if (tiles_due.size() == 0) begin
				errors++;
				$display("%0t unexpected word: got %p", $time, tile);
			end else begin
				want = tiles_due.pop_front();
				if (tile.tile_column !== want.tile_column || tile.tile_row !== want.tile_row
					|| tile.red_out !== want.red_out || tile.green_out !== want.green_out
					|| tile.blue_out !== want.blue_out || tile.frame_end !== want.frame_end) begin
					errors++;
					$display("%0t mismatch: expected %p, actual %p", $time, want, tile);
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk)
		tile_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);

	task automatic wait_drained();
		while (tiles_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [bap_pkg::CFG_IDX_W-1:0] idx,
		logic [bap_pkg::IMG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			bap_pkg::CFG_IMG_W:  reg_w = data;
			bap_pkg::CFG_IMG_H:  reg_h = data;
			bap_pkg::CFG_TILE_W: reg_tw = data[bap_pkg::TILE_W-1:0];
			bap_pkg::CFG_TILE_H: reg_th = data[bap_pkg::TILE_W-1:0];
			bap_pkg::CFG_MODE:   reg_mode = data[bap_pkg::MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drives one pixel word; when typed, the given word replaces the prediction.
	task automatic send_pix(bap_pkg::pix_t p, bit typed, bap_pkg::tile_t want);
		bap_pkg::tile_t t;
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall !== 1'b0)
			@(posedge clk);
		n_pix_sent++;
		if (predict_tile(p, t))
			tiles_due.push_back(typed ? want : t);
	endtask

	function automatic dir_row_t cfg_row(logic [bap_pkg::CFG_IDX_W-1:0] i, int d);
		return '{1'b1, i, bap_pkg::IMG_W'(d), '0, 1'b0, '0};
	endfunction

	function automatic dir_row_t px_row(logic [7:0] r, g, b, bit fs);
		return '{1'b0, bap_pkg::CFG_IMG_W, '0, '{r, g, b, fs}, 1'b0, '0};
	endfunction

	function automatic dir_row_t px_exp(logic [7:0] r, g, b, bit fs,
		int tc, int tr, logic [7:0] ro, go, bo, bit fe);
		return '{1'b0, bap_pkg::CFG_IMG_W, '0, '{r, g, b, fs}, 1'b1,
			'{10'(tc), 10'(tr), ro, go, bo, fe}};
	endfunction

	function automatic bap_pkg::pix_t rand_pix(bit fs);
		bap_pkg::pix_t p;
		p = bap_pkg::pix_t'($bits(bap_pkg::pix_t)'($urandom));
		case ($urandom_range(0, 9))
			0: begin p.red_in = 8'h00; p.green_in = 8'h00; p.blue_in = 8'h00; end
			1: begin p.red_in = 8'hff; p.green_in = 8'hff; p.blue_in = 8'hff; end
			default: ;
		endcase
		p.frame_start = fs;
		return p;
	endfunction

	dir_row_t dir_tab [N_DIR];
	setting_t phases [N_PHASE];

	initial begin
		bap_pkg::pix_t p;
		dir_tab = '{
			cfg_row(bap_pkg::CFG_MODE, bap_pkg::MODE_ORIG), cfg_row(bap_pkg::CFG_IMG_W, 2),
			cfg_row(bap_pkg::CFG_IMG_H, 2),
			px_exp(8'hff, 8'h00, 8'hff, 1, 0, 0, 8'hff, 8'h00, 8'hff, 0),
			px_exp(8'h00, 8'hff, 8'h00, 0, 1, 0, 8'h00, 8'hff, 8'h00, 0),
			px_exp(8'h01, 8'h02, 8'h03, 0, 0, 1, 8'h01, 8'h02, 8'h03, 0),
			px_exp(8'hfe, 8'hfd, 8'hfc, 0, 1, 1, 8'hfe, 8'hfd, 8'hfc, 1),
			cfg_row(bap_pkg::CFG_TILE_W, 2), cfg_row(bap_pkg::CFG_TILE_H, 2),
			cfg_row(bap_pkg::CFG_MODE, bap_pkg::MODE_CORNER),
			px_exp(8'haa, 8'hbb, 8'hcc, 1, 0, 0, 8'haa, 8'hbb, 8'hcc, 1),
			px_row(8'h11, 8'h22, 8'h33, 0), px_row(8'h44, 8'h55, 8'h66, 0),
			px_row(8'h77, 8'h88, 8'h99, 0),
			cfg_row(bap_pkg::CFG_MODE, bap_pkg::MODE_AVG),
			px_row(8'hff, 8'hff, 8'hff, 1), px_row(8'hff, 8'hff, 8'hff, 0),
			px_row(8'hff, 8'hff, 8'hff, 0),
			px_exp(8'hff, 8'hff, 8'hff, 0, 0, 0, 8'hff, 8'hff, 8'hff, 1),
			px_row(8'h00, 8'h00, 8'h00, 1), px_row(8'h00, 8'h00, 8'h00, 0),
			px_row(8'h00, 8'h00, 8'h00, 0),
			px_exp(8'h00, 8'h00, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1),
			// clipped right-hand tile, zero tile height clamps to one, mode 3
			cfg_row(bap_pkg::CFG_IMG_W, 3), cfg_row(bap_pkg::CFG_IMG_H, 1),
			cfg_row(bap_pkg::CFG_TILE_H, 0),
			cfg_row(bap_pkg::CFG_MODE, MODE_AVG_ALT),
			px_row(8'h10, 8'h20, 8'h30, 1), px_row(8'h31, 8'h41, 8'h51, 0),
			px_row(8'h07, 8'h08, 8'h09, 0)
		};
		// zero and oversized registers clamp
		phases = '{
			'{6, 4, 2, 2, bap_pkg::MODE_AVG, 220},
			'{7, 5, 3, 2, bap_pkg::MODE_CORNER, 200},
			'{0, 3, 0, 127, bap_pkg::MODE_AVG, 150},
			'{2047, 1, 127, 2, bap_pkg::MODE_AVG, 320},
			'{9, 7, 4, 3, bap_pkg::MODE_ORIG, 200},
			'{5, 2047, 5, 100, bap_pkg::MODE_CORNER, 150},
			'{11, 6, 100, 1, MODE_AVG_ALT, 200},
			'{13, 9, 5, 4, bap_pkg::MODE_AVG, 250},
			'{4, 4, 1, 1, bap_pkg::MODE_AVG, 140}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				@(negedge clk);
				pix_valid <= 1'b0;
				wait_drained();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_pix(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		foreach (phases[ph]) begin
			@(negedge clk);
			pix_valid <= 1'b0;
			wait_drained();
			write_reg(bap_pkg::CFG_IMG_W, bap_pkg::IMG_W'(phases[ph].w));
			write_reg(bap_pkg::CFG_IMG_H, bap_pkg::IMG_W'(phases[ph].h));
			write_reg(bap_pkg::CFG_TILE_W, bap_pkg::IMG_W'(phases[ph].tw));
			write_reg(bap_pkg::CFG_TILE_H, bap_pkg::IMG_W'(phases[ph].th));
			write_reg(bap_pkg::CFG_MODE, bap_pkg::IMG_W'(phases[ph].mode));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 49; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (int k = 0; k < phases[ph].n_pix; k++) begin
				// sender holds off until the output side is empty
				if (ph == 0 && k == 100) begin
					@(negedge clk);
					pix_valid <= 1'b0;
					while (tiles_due.size() != 0)
						@(posedge clk);
				end
				// occasional stray frame restart as noise
				p = rand_pix(k == 0 || $urandom_range(0, 149) == 0);
				send_pix(p, 1'b0, '0);
			end
		end

		@(negedge clk);
		pix_valid <= 1'b0;
		wait_drained();
		$display("covered %0d pixel words over %0d register settings, all four modes",
			n_pix_sent, N_PHASE + 4);
		$display("checked %0d output words, %0d mismatches", n_tiles_seen, errors);
		if (errors == 0 && tiles_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bap_pkg.sv
rtl/bap_ram.sv
rtl/block_average_pixelate_top.sv
verif/tb_block_average_pixelate_top.sv
